[hw/rtl/ordered_array_insert_delete_defines.svh]
// Assertion macros used by the checker file of the ordered array block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH

// General property checked at each rising edge outside reset.
`define OAID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked at each rising edge outside reset.
`define OAID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/oaid_pkg.sv]
// Package of the ordered array block: operation and status codes, control
// state, the per-cell control struct and default sizes. No dependencies.
package oaid_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int ENTRY_W          = 32;
  localparam int INDEX_W          = 6;
  localparam int COUNT_OUT_W      = 7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    FSM_IDLE  = 1'b0,
    FSM_SHIFT = 1'b1
  } fsm_t;

  typedef struct packed {
    logic wr_at;
    logic shift_up;
    logic shift_dn;
    logic rd_load;
    logic rd_shift;
  } cell_ctrl_t;

endpackage

[hw/rtl/oaid_cell.sv]
// One cell of the ordered array row: holds one entry and one read-out word.
// Depends on oaid_pkg for the control struct and the entry width.
module oaid_cell #(
  parameter int PW  = 7,
  parameter int POS = 0
) (
  input  logic                                  clk,
  input  oaid_pkg::cell_ctrl_t                  ctrl,
  input  logic [PW-1:0]                         key,
  input  logic signed [oaid_pkg::ENTRY_W-1:0]   value,
  input  logic signed [oaid_pkg::ENTRY_W-1:0]   left_entry,
  input  logic signed [oaid_pkg::ENTRY_W-1:0]   right_entry,
  input  logic signed [oaid_pkg::ENTRY_W-1:0]   right_rd,
  output logic signed [oaid_pkg::ENTRY_W-1:0]   entry,
  output logic signed [oaid_pkg::ENTRY_W-1:0]   rd
);
  import oaid_pkg::*;

  logic hit;
  logic above;

  assign hit   = (key == PW'(POS));
  assign above = (PW'(POS) > key);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up && above) begin
      entry <= left_entry;
    end else if (ctrl.shift_dn && (hit || above)) begin
      entry <= right_entry;
    end else if (ctrl.wr_at && hit) begin
      entry <= value;
    end
    if (ctrl.rd_load) begin
      rd <= entry;
    end else if (ctrl.rd_shift) begin
      rd <= right_rd;
    end
  end

endmodule

[hw/rtl/ordered_array_insert_delete.sv]
// Top level of the ordered array block: request decode, live count, output
// register and the row of oaid_cell instances. Depends on oaid_pkg.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  request | in_valid in_stall op index value | in
//  result  | out_valid out_stall status       | out
//          | read_value entry_count           |
//
// Append, insert, update, delete and any refused request load the result register directly.
// A read of a valid index loads the row's read-out words in parallel, then
// shifts them toward cell zero once per cycle until the indexed word is there.
// Reset clears the live count and the handshake state; entries stay as is.
// A held result beat stalls the request channel until it is taken.
module ordered_array_insert_delete #(
  parameter int CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [2:0]                              op,
  input  logic [oaid_pkg::INDEX_W-1:0]            index,
  input  logic signed [oaid_pkg::ENTRY_W-1:0]     value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              status,
  output logic signed [oaid_pkg::ENTRY_W-1:0]     read_value,
  output logic [oaid_pkg::COUNT_OUT_W-1:0]        entry_count
);
  import oaid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  fsm_t                      fsm, fsm_next;
  logic [CW-1:0]             count, count_next;
  logic [INDEX_W-1:0]        cnt, cnt_next;
  cell_ctrl_t                ctrl;
  logic [PW-1:0]             key;
  logic [PW-1:0]             cnt_ext;
  logic [PW-1:0]             idx_ext;
  logic                      in_fire;
  logic                      idx_ok;
  logic                      full;
  logic                      ld_out;
  status_t                   st_n;
  logic signed [ENTRY_W-1:0] rd_n;

  logic signed [ENTRY_W-1:0] ent   [CAPACITY];
  logic signed [ENTRY_W-1:0] rdw   [CAPACITY];
  logic signed [ENTRY_W-1:0] left_n  [CAPACITY];
  logic signed [ENTRY_W-1:0] right_n [CAPACITY];
  logic signed [ENTRY_W-1:0] rdr_n   [CAPACITY];

  assign cnt_ext = PW'(count);
  assign idx_ext = PW'(index);
  assign idx_ok  = (idx_ext < cnt_ext);
  assign full    = (cnt_ext == PW'(CAPACITY));
  assign in_stall = (fsm != FSM_IDLE) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    fsm_next   = fsm;
    count_next = count;
    cnt_next   = cnt;
    ctrl       = '0;
    key        = idx_ext;
    ld_out     = 1'b0;
    st_n       = ST_DONE;
    rd_n       = '0;
    case (fsm)
      FSM_IDLE: begin
        if (in_fire) begin
          ld_out = 1'b1;
          case (op_t'(op))
            OP_APPEND: begin
              key = cnt_ext;
              if (full) begin
                st_n = ST_FULL;
              end else begin
                ctrl.wr_at = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_INSERT: begin
              if (!idx_ok) begin
                st_n = ST_OOB;
              end else if (full) begin
                st_n = ST_FULL;
              end else begin
                ctrl.wr_at    = 1'b1;
                ctrl.shift_up = 1'b1;
                count_next    = count + CW'(1);
              end
            end
            OP_UPDATE: begin
              if (!idx_ok) begin
                st_n = ST_OOB;
              end else begin
                ctrl.wr_at = 1'b1;
              end
            end
            OP_DELETE: begin
              if (!idx_ok) begin
                st_n = ST_OOB;
              end else begin
                ctrl.shift_dn = 1'b1;
                count_next    = count - CW'(1);
              end
            end
            OP_READ: begin
              if (!idx_ok) begin
                st_n = ST_OOB;
              end else begin
                ld_out       = 1'b0;
                ctrl.rd_load = 1'b1;
                cnt_next     = index;
                fsm_next     = FSM_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_SHIFT: begin
        if (cnt == '0) begin
          ld_out   = 1'b1;
          rd_n     = rdw[0];
          fsm_next = FSM_IDLE;
        end else begin
          ctrl.rd_shift = 1'b1;
          cnt_next      = cnt - INDEX_W'(1);
        end
      end
      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FSM_IDLE;
      count     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      fsm   <= fsm_next;
      count <= count_next;
      cnt   <= cnt_next;
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      status      <= st_n;
      read_value  <= rd_n;
      entry_count <= COUNT_OUT_W'(PW'(count_next));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_n[g] = '0;
    end else begin : g_mid_left
      assign left_n[g] = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_n[g] = '0;
      assign rdr_n[g]   = '0;
    end else begin : g_mid_right
      assign right_n[g] = ent[g+1];
      assign rdr_n[g]   = rdw[g+1];
    end
    oaid_cell #(
      .PW  (PW),
      .POS (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .value       (value),
      .left_entry  (left_n[g]),
      .right_entry (right_n[g]),
      .right_rd    (rdr_n[g]),
      .entry       (ent[g]),
      .rd          (rdw[g])
    );
  end

endmodule

[hw/rtl/oaid_checker.sv]
// Port-level checker of the ordered array block and its bind statement.
// Depends on oaid_pkg and the assertion macros of the defines header.
`include "ordered_array_insert_delete_defines.svh"

module oaid_checker #(
  parameter int CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [1:0]                           status,
  input logic signed [oaid_pkg::ENTRY_W-1:0]  read_value,
  input logic [oaid_pkg::COUNT_OUT_W-1:0]     entry_count
);
  import oaid_pkg::*;

  localparam logic [COUNT_OUT_W-1:0] FULL_CNT = COUNT_OUT_W'(CAPACITY);
  localparam bit CNT_FITS = (CAPACITY < 128);

  logic held;
  logic err_beat;
  logic full_beat;
  logic cnt_beat;

  assign held      = out_valid && out_stall;
  assign err_beat  = out_valid && (status != ST_DONE);
  assign full_beat = out_valid && (status == ST_FULL);
  assign cnt_beat  = out_valid && CNT_FITS;

  // A result beat that is held must stay valid until it is taken.
  `OAID_ASSERT(a_out_hold, held |=> out_valid, "held result beat dropped")

  // A waiting result blocks new requests.
  `OAID_ASSERT_IMP(a_in_block, held, in_stall, "request taken over held result")

  // Refused requests never carry read data.
  `OAID_ASSERT_IMP(a_err_zero, err_beat, read_value == '0, "error beat with read data")

  // A full refusal reports a count equal to the capacity.
  `OAID_ASSERT_IMP(a_full_cnt, full_beat, entry_count == FULL_CNT, "full beat, wrong count")

  // The count never exceeds the capacity where it fits the output.
  `OAID_ASSERT_IMP(a_cnt_max, cnt_beat, int'(entry_count) <= CAPACITY, "count above capacity")

endmodule

bind ordered_array_insert_delete oaid_checker #(
  .CAPACITY (CAPACITY)
) u_oaid_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .entry_count (entry_count)
);
